[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the hash core checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted (active low)
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked property, checked during reset as well
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, round constants and round functions shared by the hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

    localparam int WORD_W  = 32;
    localparam int BLK_WORDS = 16;
    localparam int ROUNDS  = 64;
    localparam int HASH_WORDS = 8;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_ROUND,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic       load_word;
        logic       init_work;
        logic       round_en;
        logic       chain_add;
        logic       chain_reset;
        logic       dig_load;
        logic       dig_shift;
        logic [5:0] round_idx;
    } dp_cmd_t;

    localparam word_t INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

[rtl/core/sha256_word_stream_hash.sv]
// ----------------------------------------------------------------------------
// sha256_word_stream_hash
// SHA-256 over a padded message streamed as 32-bit big-endian words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one padded message word per item in s_tdata, with
//   s_tlast set on the final word of the message. s_tlast is honored only
//   on the 16th word of a 512-bit block and ignored elsewhere.
//   Master channel m_*: eight digest words H0..H7, index in m_tuser,
//   m_tlast on the eighth.
//   Timing: the 16 words of a block are taken one per cycle while s_tvalid
//   is high; the 16th starts the 64 compression rounds (one round per cycle),
//   followed by a chain update, and no word is taken until the update is done.
//   After the final block the digest is loaded into its buffer in the update
//   step, then leaves one word per cycle while m_tready is high.
//   The digest sits in its own buffer, so the next message is taken while
//   the previous digest drains; a stalled receiver holds the item and only
//   blocks the core when a further digest is ready.
//   Reset (aresetn low, synchronous) restores the initial hash, empties the
//   block and drops any pending digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_word_stream_hash
    import sha256_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] msg_word
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] digest_index
    output logic             m_tlast
);

    dp_cmd_t cmd;

    sha256_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd)
    );

    sha256_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_word  (s_tdata),
        .dig_word (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/core/sha256_datapath.sv]
// ----------------------------------------------------------------------------
// sha256_datapath
// Schedule window, working variables, chaining value and digest buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire dp_cmd_t cmd,
    input  wire word_t   in_word,
    output word_t        dig_word
);

    word_t w_reg     [BLK_WORDS];
    word_t v_reg     [HASH_WORDS];
    word_t chain_reg [HASH_WORDS];
    word_t dig_reg   [HASH_WORDS];

    word_t w_next;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;
    word_t sum     [HASH_WORDS];

    always_comb begin
        w_next = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1     = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[cmd.round_idx] + w_reg[0];
        t2     = big_sigma0(v_reg[0]) + maj;
        for (int i = 0; i < HASH_WORDS; i++) begin
            sum[i] = chain_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLK_WORDS-1] <= in_word;
        end else if (cmd.round_en) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLK_WORDS-1] <= w_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init_work) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                v_reg[i] <= chain_reg[i];
            end
        end else if (cmd.round_en) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end else if (cmd.chain_reset) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end else if (cmd.chain_add) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_reg[i] <= sum[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dig_load) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                dig_reg[i] <= sum[i];
            end
        end else if (cmd.dig_shift) begin
            for (int i = 0; i < HASH_WORDS - 1; i++) begin
                dig_reg[i] <= dig_reg[i+1];
            end
            dig_reg[HASH_WORDS-1] <= dig_reg[HASH_WORDS-1];
        end
    end

    assign dig_word = dig_reg[0];

endmodule

`default_nettype wire

[rtl/core/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// sha256_ctrl
// Block sequencer: word collection, round count, chain update, digest drain.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    input  wire logic  s_tlast,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [2:0] m_tuser,
    output logic       m_tlast,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [5:0]  round_reg, round_next;
    logic        last_reg, last_next;
    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;

    logic        in_fire;
    logic        out_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            pos_reg   <= '0;
            round_reg <= '0;
            last_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            round_reg <= round_next;
            last_reg  <= last_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        round_next = round_reg;
        last_next  = last_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.round_idx = round_reg;

        s_tready = (state_reg == ST_COLLECT);
        in_fire  = s_tvalid && s_tready;
        out_fire = busy_reg && m_tready;

        // drain digest
        if (out_fire) begin
            cmd.dig_shift = 1'b1;
            idx_next      = idx_reg + 3'd1;
            if (idx_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_COLLECT: begin
                if (in_fire) begin
                    cmd.load_word = 1'b1;
                    pos_next      = pos_reg + 4'd1;
                    if (pos_reg == 4'd15) begin
                        cmd.init_work = 1'b1;
                        last_next     = s_tlast;
                        round_next    = '0;
                        state_next    = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!last_reg) begin
                    cmd.chain_add = 1'b1;
                    state_next    = ST_COLLECT;
                end else if (!busy_reg) begin
                    cmd.dig_load    = 1'b1;
                    cmd.chain_reset = 1'b1;
                    busy_next       = 1'b1;
                    idx_next        = '0;
                    state_next      = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase

        m_tvalid = busy_reg;
        m_tuser  = idx_reg;
        m_tlast  = (idx_reg == 3'd7);
    end

endmodule

`default_nettype wire

[rtl/core/sha256_checker.sv]
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the digest channel and reset state of the hash core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sha256_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    `ASSERT_CLK_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "digest item changed while stalled")

    `ASSERT_CLK_RST(a_burst_seq, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == 3'($past(m_tuser) + 3'd1)), "digest words not contiguous")

    `ASSERT_CLK_RST(a_last_idx, aclk, aresetn, m_tvalid |-> (m_tlast == (m_tuser == 3'd7)), "last flag not on eighth digest word")

    `ASSERT_CLK(a_reset_idle, aclk, !aresetn |=> !m_tvalid && s_tready, "core not idle after reset")

endmodule

bind sha256_word_stream_hash sha256_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
